[rtl/bounded_deque_engine_macros.svh]
// Assertion macros shared by the deque engine.
// Each check samples on clk and is disabled while rst is high.
`ifndef BOUNDED_DEQUE_ENGINE_MACROS_SVH
`define BOUNDED_DEQUE_ENGINE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define BDE_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque engine check failed");

// Next-cycle implication.
`define BDE_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque engine check failed");

`else

`define BDE_ASSERT_IMPLY(name, ante, cons)
`define BDE_ASSERT_NEXT(name, ante, cons)

`endif

`endif

[rtl/bde_pkg.sv]
package bde_pkg;

  // Storage depth default and the most results one view may produce
  localparam int DEPTH_DEFAULT = 64;
  localparam int RESULT_LIMIT  = 64;

  // Count and capacity width (holds 0..64)
  localparam int CNT_W = 7;
  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

  // Action codes
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_BACK   = 3'd3;
  localparam logic [2:0] ACT_VIEW       = 3'd4;

  // Status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_EMPTY   = 2'd2;
  localparam logic [1:0] STATUS_INVALID = 2'd3;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] push_value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] element_value;
    logic               last;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture the request
    logic exec;   // carry out the action
    logic view;   // emit one view element and advance
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic view_go;   // view of a non-empty deque
    logic view_end;  // current view element is the last one
  } dp_sts_t;

endpackage

[rtl/bounded_deque_engine.sv]
// Channel   Ports                       Transfer
// request   start, busy, req            accepted when start && !busy
// result    done, rsp                   one result per cycle, no hold-off
// config    cfg_we, cfg_data            written when cfg_we is high
//
// Push, pop, invalid action and view of an empty deque run in two steps:
// capture the request, then update state and load the result register.
// A view of N elements returns its results one per cycle, paced by the
// single registered read port of the element memory.
// rst (synchronous) empties the deque and sets capacity to 64; the memory
// needs no clearing. Results always flow, the receiver cannot stall them.
`include "bounded_deque_engine_macros.svh"

module bounded_deque_engine import bde_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  req_t             req,
  output logic             done,
  output rsp_t             rsp,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  bde_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  bde_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .done     (done),
    .rsp      (rsp)
  );

  // An accepted request keeps the engine busy for its execute cycle
  `BDE_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // Refusals and errors end the request at once
  `BDE_ASSERT_IMPLY(a_refuse_last, done && (rsp.status != STATUS_OK), rsp.last)
  // Only view elements carry a value
  `BDE_ASSERT_IMPLY(a_refuse_zero, done && (rsp.status != STATUS_OK), rsp.element_value == 0)
  // View elements come out back to back until the last one
  `BDE_ASSERT_NEXT(a_view_run, done && !rsp.last, done)

endmodule

[rtl/bde_ram.sv]
module bde_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/bde_ctrl.sv]
module bde_ctrl import bde_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  dp_sts_t sts,
  output dp_cmd_t cmd,
  output logic    busy
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_VIEW = 3'b100
  } state_t;

  state_t state, state_next;

  // Advance the controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.view_go ? ST_VIEW : ST_IDLE;
      end
      ST_VIEW: begin
        cmd.view = 1'b1;
        if (sts.view_end) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

[rtl/bde_dp.sv]
module bde_dp import bde_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  req_t             req,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data,
  input  dp_cmd_t          cmd,
  output dp_sts_t          sts,
  output logic             done,
  output rsp_t             rsp
);

  localparam int PW    = $clog2(DEPTH);
  localparam int SW    = ((PW > CNT_W) ? PW : CNT_W) + 1;
  localparam int LIMIT = (DEPTH < RESULT_LIMIT) ? DEPTH : RESULT_LIMIT;

  localparam logic [SW-1:0]    DEPTH_S = SW'(DEPTH);
  localparam logic [PW-1:0]    LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(LIMIT);

  logic [CNT_W-1:0] capacity;
  logic [CNT_W-1:0] count, count_next;
  logic [PW-1:0]    front, front_next;
  logic [CNT_W-1:0] idx;
  req_t             cur;

  logic [CNT_W-1:0] limit;
  logic             full, empty;
  logic [CNT_W-1:0] offset;
  logic [SW-1:0]    slot_sum, slot_wrap;
  logic [PW-1:0]    slot, front_dec, front_inc;
  logic [CNT_W-1:0] idx_inc;

  logic             we;
  logic [PW-1:0]    waddr;
  logic [31:0]      rdata;
  logic [1:0]       exec_status;

  // Hold the capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= req;
    end
  end

  assign limit = (capacity > LIMIT_C) ? LIMIT_C : capacity;
  assign full  = (count >= limit);
  assign empty = (count == '0);

  // Slot address: front plus an offset, wrapped once
  assign idx_inc   = idx + 1'b1;
  assign offset    = cmd.exec ? ((cur.action == ACT_PUSH_BACK) ? count : '0) : idx_inc;
  assign slot_sum  = SW'(front) + SW'(offset);
  assign slot_wrap = (slot_sum >= DEPTH_S) ? (slot_sum - DEPTH_S) : slot_sum;
  assign slot      = slot_wrap[PW-1:0];
  assign front_dec = (front == '0) ? LAST_SLOT : (front - 1'b1);
  assign front_inc = (front == LAST_SLOT) ? '0 : (front + 1'b1);

  // Decide the action outcome
  always_comb begin
    exec_status = STATUS_OK;
    we          = 1'b0;
    waddr       = slot;
    count_next  = count;
    front_next  = front;
    case (cur.action)
      ACT_PUSH_FRONT: begin
        if (full) begin
          exec_status = STATUS_FULL;
        end else begin
          we         = cmd.exec;
          waddr      = front_dec;
          front_next = front_dec;
          count_next = count + 1'b1;
        end
      end
      ACT_PUSH_BACK: begin
        if (full) begin
          exec_status = STATUS_FULL;
        end else begin
          we         = cmd.exec;
          count_next = count + 1'b1;
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          exec_status = STATUS_EMPTY;
        end else begin
          front_next = front_inc;
          count_next = count - 1'b1;
        end
      end
      ACT_POP_BACK: begin
        if (empty) begin
          exec_status = STATUS_EMPTY;
        end else begin
          count_next = count - 1'b1;
        end
      end
      ACT_VIEW: begin
        if (empty) begin
          exec_status = STATUS_EMPTY;
        end
      end
      default: begin
        exec_status = STATUS_INVALID;
      end
    endcase
  end

  assign sts.view_go  = (cur.action == ACT_VIEW) && !empty;
  assign sts.view_end = (idx_inc == count);

  // Update count and front
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      front <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
      front <= front_next;
    end
  end

  // Walk the view index
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      idx <= '0;
    end else if (cmd.view) begin
      idx <= idx_inc;
    end
  end

  bde_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (cur.push_value),
    .raddr (slot),
    .rdata (rdata)
  );

  // Drive the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cmd.exec && !sts.view_go) || cmd.view;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (cmd.view) begin
      rsp.status        <= STATUS_OK;
      rsp.element_value <= rdata;
      rsp.last          <= sts.view_end;
    end else if (cmd.exec) begin
      rsp.status        <= exec_status;
      rsp.element_value <= '0;
      rsp.last          <= 1'b1;
    end
  end

endmodule
